### src/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared types, register codes, reset values and widths for the disparity
// to point reprojection pipeline.
// ----------------------------------------------------------------------------
package dpr_pkg;

	// configuration port
	localparam int IDX_W = 3;
	localparam int CFG_W = 18;

	localparam logic [IDX_W-1:0] REG_FOCAL_X      = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTRE_X     = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTRE_Y     = 3'd3;
	localparam logic [IDX_W-1:0] REG_BASELINE     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEPTH_LIMIT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_HEIGHT_LIMIT = 3'd6;

	localparam logic [15:0] RST_FOCAL_X      = 16'd15748;
	localparam logic [15:0] RST_FOCAL_Y      = 16'd15693;
	localparam logic [15:0] RST_CENTRE_X     = 16'd11040;
	localparam logic [15:0] RST_CENTRE_Y     = 16'd3731;
	localparam logic [17:0] RST_BASELINE     = 18'd35193;
	localparam logic [15:0] RST_DEPTH_LIMIT  = 16'd20000;
	localparam logic [15:0] RST_HEIGHT_LIMIT = 16'd3000;

	// disparity window in 1/16 px: 5 px < d < 96 px
	localparam logic signed [11:0] DISP_LO = 12'sd80;
	localparam logic signed [11:0] DISP_HI = 12'sd1536;

	// divider geometry
	localparam int D_W      = 11;          // disparity inside the window
	localparam int GD_W     = 27;          // focal_y * disparity
	localparam int QW       = 17;          // quotient bits per lane
	localparam int LANE_LAT = QW + 1;      // entry stage plus one cell per bit

	localparam logic [9:0] MM_PER_M = 10'd1000;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// sideband riding alongside the divider lanes
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic stk_z;   // low 16 bits of depth numerator nonzero
		logic stk_y;   // low 16 bits of y numerator nonzero
		rgb_t rgb;
	} tag_t;

	// sign and magnitude to a 17-bit two's complement value, clamped
	function automatic logic [16:0] clamp_coord(logic neg, logic ovf, logic [16:0] mag);
		logic [16:0] res;
		if (!neg) begin
			res = (ovf || mag[16]) ? 17'h0FFFF : {1'b0, mag[15:0]};
		end else begin
			res = (ovf || mag > 17'h10000) ? 17'h10000 : 17'd0 - mag;
		end
		return res;
	endfunction

endpackage

### src/dpr_div_cell.sv
// ----------------------------------------------------------------------------
// dpr_div_cell
// One restoring division step: brings in the next numerator bit, trial
// subtracts the divisor and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module dpr_div_cell #(
	parameter int DW = 11,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] nq_in,
	input  logic [DW-1:0] dvs_in,
	output logic [DW-1:0] rem_out,
	output logic [QW-1:0] nq_out,
	output logic [DW-1:0] dvs_out
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] nq_q;
	logic [DW-1:0] dvs_q;

	// numerator bits leave at the top of nq while quotient bits enter below
	always_comb begin
		trial = {rem_in, nq_in[QW-1]};
		diff  = trial - {1'b0, dvs_in};
		ge    = trial >= {1'b0, dvs_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_q  <= {nq_in[QW-2:0], ge};
			dvs_q <= dvs_in;
		end
	end

	assign rem_out = rem_q;
	assign nq_out  = nq_q;
	assign dvs_out = dvs_q;

endmodule

### src/dpr_div_lane.sv
// ----------------------------------------------------------------------------
// dpr_div_lane
// Pipelined divider: an entry stage that flags quotient overflow, then a
// chain of QW cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
module dpr_div_lane #(
	parameter int DW = 11,
	parameter int QW = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0]    dvs,
	output logic [QW-1:0]    quo,
	output logic [DW-1:0]    rem,
	output logic             ovf
);

	logic [DW-1:0] top;
	logic          top_ge;
	logic [DW-1:0] rem_s1;
	logic [QW-1:0] nq_s1;
	logic [DW-1:0] dvs_s1;
	logic          ovf_s1;
	logic          ovf_q [QW];

	logic [DW-1:0] rem_w [QW+1];
	logic [QW-1:0] nq_w  [QW+1];
	logic [DW-1:0] dvs_w [QW+1];

	// quotient fits QW bits only when the upper numerator part is below the divisor
	assign top    = num[DW+QW-1:QW];
	assign top_ge = top >= dvs;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= top_ge ? '0 : top;
			nq_s1  <= num[QW-1:0];
			dvs_s1 <= dvs;
			ovf_s1 <= top_ge;
		end
	end

	assign rem_w[0] = rem_s1;
	assign nq_w[0]  = nq_s1;
	assign dvs_w[0] = dvs_s1;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		dpr_div_cell #(
			.DW(DW),
			.QW(QW)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_in (rem_w[i]),
			.nq_in  (nq_w[i]),
			.dvs_in (dvs_w[i]),
			.rem_out(rem_w[i+1]),
			.nq_out (nq_w[i+1]),
			.dvs_out(dvs_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= ovf_s1;
			for (int i = 1; i < QW; i++) begin
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	assign quo = nq_w[QW];
	assign rem = rem_w[QW];
	assign ovf = ovf_q[QW-1];

endmodule

### src/disparity_to_point_reprojection.sv
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Stereo disparity to 3-D point: windows the disparity, forms the depth and
// back-projected x/y numerators, divides them in three cell-chain lanes and
// applies the depth and height cuts.
//
//   channel  handshake            beat payload
//   cfg      cfg_we               cfg_index, cfg_data
//   in       in_valid / in_stall  column, row, disparity_raw, blue/green/red_in
//   out      out_valid / out_stall point_x, point_y, point_z, blue/green/red_out
//
// One pixel per cycle sustained while out is not stalled; a point reaches out
// through the input register, four multiply stages, an 18-stage divider
// chain (one quotient bit per cell) and the output register.
// The whole pipe holds while the output beat is stalled and the last divider
// stage carries a pixel; bubbles ahead of that still fill.
// Reset clears valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_we,
	input  logic [dpr_pkg::IDX_W-1:0] cfg_index,
	input  logic [dpr_pkg::CFG_W-1:0] cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [11:0]              column,
	input  logic [11:0]              row,
	input  logic signed [11:0]       disparity_raw,
	input  logic [7:0]               blue_in,
	input  logic [7:0]               green_in,
	input  logic [7:0]               red_in,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [16:0]       point_x,
	output logic signed [16:0]       point_y,
	output logic [15:0]              point_z,
	output logic [7:0]               blue_out,
	output logic [7:0]               green_out,
	output logic [7:0]               red_out
);

	localparam int LAT = dpr_pkg::LANE_LAT;

	// configuration
	logic [15:0] focal_x_q, focal_y_q, centre_x_q, centre_y_q;
	logic [17:0] baseline_q;
	logic [15:0] depth_lim_q, height_lim_q;

	// pipeline
	logic                     en;
	logic                     out_free;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [11:0]              col_s1, row_s1;
	logic signed [11:0]       disp_s1;
	dpr_pkg::rgb_t            rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic                     win;
	logic [15:0]              focal_y_eff;
	logic [33:0]              fb_s2;
	logic [16:0]              sx_s2, sy_s2;
	logic [dpr_pkg::GD_W-1:0] gd_s2, gd_s3, gd_s4, gd_s5;
	logic [dpr_pkg::D_W-1:0]  d_s2, d_s3, d_s4, d_s5;
	logic [16:0]              nsx, nsy;
	logic [15:0]              abs_x, abs_y;
	logic [43:0]              zn_s3, zn_s4, zn_s5;
	logic [33:0]              ax_s3;
	logic [31:0]              ay_s3;
	logic                     negx_s3, negy_s3, negx_s4, negy_s4, negx_s5, negy_s5;
	logic [43:0]              xm_s4, xm_s5;
	logic [49:0]              ym_s4;
	logic [59:0]              ym_s5;
	dpr_pkg::tag_t            tag_s5;
	dpr_pkg::tag_t            tag_q [LAT];
	logic                     vld_q [LAT];

	// divider results
	logic [dpr_pkg::QW-1:0]   qz, qx, qy;
	logic [dpr_pkg::D_W-1:0]  rz, rx;
	logic [dpr_pkg::GD_W-1:0] ry;
	logic                     oz, ox, oy;
	dpr_pkg::tag_t            tag_l;
	logic                     vld_l;
	logic                     drop_z, drop_y, pass;

	logic                     out_valid_q;
	logic [16:0]              px_q, py_q;
	logic [15:0]              pz_q;
	dpr_pkg::rgb_t            rgb_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= dpr_pkg::RST_FOCAL_X;
			focal_y_q    <= dpr_pkg::RST_FOCAL_Y;
			centre_x_q   <= dpr_pkg::RST_CENTRE_X;
			centre_y_q   <= dpr_pkg::RST_CENTRE_Y;
			baseline_q   <= dpr_pkg::RST_BASELINE;
			depth_lim_q  <= dpr_pkg::RST_DEPTH_LIMIT;
			height_lim_q <= dpr_pkg::RST_HEIGHT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpr_pkg::REG_FOCAL_X:      focal_x_q    <= cfg_data[15:0];
				dpr_pkg::REG_FOCAL_Y:      focal_y_q    <= cfg_data[15:0];
				dpr_pkg::REG_CENTRE_X:     centre_x_q   <= cfg_data[15:0];
				dpr_pkg::REG_CENTRE_Y:     centre_y_q   <= cfg_data[15:0];
				dpr_pkg::REG_BASELINE:     baseline_q   <= cfg_data;
				dpr_pkg::REG_DEPTH_LIMIT:  depth_lim_q  <= cfg_data[15:0];
				dpr_pkg::REG_HEIGHT_LIMIT: height_lim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ flow control
	assign out_free = !out_valid_q || !out_stall;
	assign vld_l    = vld_q[LAT-1];
	assign en       = out_free || !vld_l;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1 && win;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_q[0] <= vld_s5;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// ------------------------------------------------------------- s1: input
	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= column;
			row_s1  <= row;
			disp_s1 <= disparity_raw;
			rgb_s1  <= '{blue: blue_in, green: green_in, red: red_in};
		end
	end

	// ------------------------------------------------ s2: offsets, F*B, G*d
	assign win         = (disp_s1 > dpr_pkg::DISP_LO) && (disp_s1 < dpr_pkg::DISP_HI);
	assign focal_y_eff = (focal_y_q == 16'd0) ? 16'd1 : focal_y_q;

	always_ff @(posedge clk) begin
		if (en) begin
			fb_s2  <= 34'(focal_x_q) * 34'(baseline_q);
			sx_s2  <= 17'({col_s1, 4'b0000}) - 17'(centre_x_q);
			sy_s2  <= 17'({row_s1, 4'b0000}) - 17'(centre_y_q);
			gd_s2  <= 27'(focal_y_eff) * 27'(disp_s1[dpr_pkg::D_W-1:0]);
			d_s2   <= disp_s1[dpr_pkg::D_W-1:0];
			rgb_s2 <= rgb_s1;
		end
	end

	// ------------------------------------------------------ s3: first products
	assign nsx   = 17'd0 - sx_s2;
	assign nsy   = 17'd0 - sy_s2;
	assign abs_x = sx_s2[16] ? nsx[15:0] : sx_s2[15:0];
	assign abs_y = sy_s2[16] ? nsy[15:0] : sy_s2[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			zn_s3   <= 44'(fb_s2) * 44'(dpr_pkg::MM_PER_M);
			ax_s3   <= 34'(abs_x) * 34'(baseline_q);
			ay_s3   <= 32'(abs_y) * 32'(focal_x_q);
			negx_s3 <= sx_s2[16];
			negy_s3 <= sy_s2[16];
			gd_s3   <= gd_s2;
			d_s3    <= d_s2;
			rgb_s3  <= rgb_s2;
		end
	end

	// ----------------------------------------------------- s4: second products
	always_ff @(posedge clk) begin
		if (en) begin
			zn_s4   <= zn_s3;
			xm_s4   <= 44'(ax_s3) * 44'(dpr_pkg::MM_PER_M);
			ym_s4   <= 50'(ay_s3) * 50'(baseline_q);
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			gd_s4   <= gd_s3;
			d_s4    <= d_s3;
			rgb_s4  <= rgb_s3;
		end
	end

	// ------------------------------------------------------ s5: y numerator
	always_ff @(posedge clk) begin
		if (en) begin
			zn_s5   <= zn_s4;
			xm_s5   <= xm_s4;
			ym_s5   <= 60'(ym_s4) * 60'(dpr_pkg::MM_PER_M);
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			gd_s5   <= gd_s4;
			d_s5    <= d_s4;
			rgb_s5  <= rgb_s4;
		end
	end

	// the 65536 in each denominator is taken off the numerators here; the
	// dropped low bits only matter for the exact limit compares
	always_comb begin
		tag_s5.neg_x = negx_s5;
		tag_s5.neg_y = negy_s5;
		tag_s5.stk_z = |zn_s5[15:0];
		tag_s5.stk_y = |ym_s5[15:0];
		tag_s5.rgb   = rgb_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag_s5;
			for (int i = 1; i < LAT; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	dpr_div_lane #(
		.DW(dpr_pkg::D_W),
		.QW(dpr_pkg::QW)
	) u_lane_z (
		.clk(clk),
		.en (en),
		.num(zn_s5[43:16]),
		.dvs(d_s5),
		.quo(qz),
		.rem(rz),
		.ovf(oz)
	);

	dpr_div_lane #(
		.DW(dpr_pkg::D_W),
		.QW(dpr_pkg::QW)
	) u_lane_x (
		.clk(clk),
		.en (en),
		.num(xm_s5[43:16]),
		.dvs(d_s5),
		.quo(qx),
		.rem(rx),
		.ovf(ox)
	);

	dpr_div_lane #(
		.DW(dpr_pkg::GD_W),
		.QW(dpr_pkg::QW)
	) u_lane_y (
		.clk(clk),
		.en (en),
		.num(ym_s5[59:16]),
		.dvs(gd_s5),
		.quo(qy),
		.rem(ry),
		.ovf(oy)
	);

	// ------------------------------------------------------- cuts and output
	assign tag_l = tag_q[LAT-1];

	// exact ratio > limit: quotient above it, or equal with anything left over
	assign drop_z = oz || (qz > 17'(depth_lim_q))
		|| ((qz == 17'(depth_lim_q)) && ((rz != '0) || tag_l.stk_z));
	assign drop_y = tag_l.neg_y && (oy || (qy > 17'(height_lim_q))
		|| ((qy == 17'(height_lim_q)) && ((ry != '0) || tag_l.stk_y)));
	assign pass   = vld_l && !drop_z && !drop_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && out_free) begin
			out_valid_q <= pass;
		end
	end

	always_ff @(posedge clk) begin
		if (en && out_free && pass) begin
			px_q  <= dpr_pkg::clamp_coord(tag_l.neg_x, ox, qx);
			py_q  <= dpr_pkg::clamp_coord(tag_l.neg_y, oy, qy);
			pz_q  <= (oz || qz[16]) ? 16'hFFFF : qz[15:0];
			rgb_q <= tag_l.rgb;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = px_q;
	assign point_y   = py_q;
	assign point_z   = pz_q;
	assign blue_out  = rgb_q.blue;
	assign green_out = rgb_q.green;
	assign red_out   = rgb_q.red;

endmodule
